// File: hdl/bcu_pkg.sv
`default_nettype none

package bcu_pkg;

    localparam int BCU_MAX_N  = 63;
    localparam int N_W        = 6;
    localparam int COEF_W     = 60;
    localparam int PROD_W     = COEF_W + N_W;
    localparam int DIV_CNT_W  = $clog2(PROD_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// File: hdl/bcu_if.sv
`default_nettype none

interface bcu_in_if import bcu_pkg::*;;
    logic           valid;
    logic           ready;
    logic [N_W-1:0] n_value;
    logic [N_W-1:0] k_value;

    modport source (output valid, output n_value, output k_value, input ready);
    modport sink   (input valid, input n_value, input k_value, output ready);
endinterface

interface bcu_out_if import bcu_pkg::*;;
    logic              valid;
    logic              ready;
    logic [COEF_W-1:0] coefficient;

    modport source (output valid, output coefficient, input ready);
    modport sink   (input valid, input coefficient, output ready);
endinterface

`default_nettype wire

// File: hdl/bcu_div.sv
`default_nettype none

module bcu_div import bcu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_dividend,
    input  wire logic [N_W-1:0]    i_divisor,
    output logic      [PROD_W-1:0] o_quotient,
    output logic                   o_done
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [N_W-1:0]       r_rem;
    logic [N_W-1:0]       r_div;
    logic [PROD_W-1:0]    r_quo;

    logic [N_W:0]         w_trial;
    logic                 w_qbit;
    logic [N_W-1:0]       w_rem;

    // restoring step: one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[PROD_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_div});
        if (w_qbit) begin
            w_rem = N_W'(w_trial - {1'b0, r_div});
        end else begin
            w_rem = w_trial[N_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_quo <= {r_quo[PROD_W-2:0], w_qbit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

// File: hdl/binomial_coefficient_unit_top.sv
// Result: valid in the cycle after the input transaction when the folded k
// is 0 or 1 (or k exceeds n), otherwise after k - 1 multiply-divide steps.
// Flow: one transaction at a time; a new one is taken only after the result
// has been accepted at the output. Each step is a 60x6 multiply, a restoring
// divide of the 66-bit product by the step index, and taking the quotient.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
`default_nettype none

module binomial_coefficient_unit_top import bcu_pkg::*; #(
    parameter int MAX_N = BCU_MAX_N
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bcu_in_if.sink     i_in,
    bcu_out_if.source  o_out
);

    t_state             r_state, n_state;
    logic [N_W-1:0]     r_n, n_n;
    logic [N_W-1:0]     r_kf, n_kf;
    logic [N_W-1:0]     r_step, n_step;
    logic [COEF_W-1:0]  r_prod, n_prod;

    logic [N_W-1:0]     w_n_sat;
    logic [N_W-1:0]     w_k_sat;
    logic [N_W-1:0]     w_k_fold;
    logic [N_W-1:0]     w_mult;
    logic               w_start;
    logic [PROD_W-1:0]  w_wide;
    logic [PROD_W-1:0]  w_quo;
    logic               w_done;

    assign w_n_sat  = (i_in.n_value > N_W'(MAX_N)) ? N_W'(MAX_N) : i_in.n_value;
    assign w_k_sat  = (i_in.k_value > N_W'(MAX_N)) ? N_W'(MAX_N) : i_in.k_value;
    assign w_k_fold = ({1'b0, w_k_sat, 1'b0} > {2'b00, w_n_sat}) ?
                      N_W'(w_n_sat - w_k_sat) : w_k_sat;
    assign w_mult   = N_W'({1'b0, r_n} - {1'b0, r_step} + 1'b1);
    assign w_wide   = PROD_W'(r_prod) * PROD_W'(w_mult);

    bcu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_wide),
        .i_divisor  (r_step),
        .o_quotient (w_quo),
        .o_done     (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_kf   <= '0;
            r_step <= '0;
            r_prod <= '0;
        end else begin
            r_n    <= n_n;
            r_kf   <= n_kf;
            r_step <= n_step;
            r_prod <= n_prod;
        end
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_kf    = r_kf;
        n_step  = r_step;
        n_prod  = r_prod;
        w_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_n    = w_n_sat;
                    n_step = N_W'(2);
                    if (w_k_sat > w_n_sat) begin
                        n_kf    = '0;
                        n_prod  = '0;
                        n_state = S_OUT;
                    end else if (w_k_fold == '0) begin
                        n_kf    = '0;
                        n_prod  = COEF_W'(1);
                        n_state = S_OUT;
                    end else begin
                        n_kf   = w_k_fold;
                        n_prod = COEF_W'(w_n_sat);
                        if (w_k_fold == N_W'(1)) begin
                            n_state = S_OUT;
                        end else begin
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_MUL: begin
                w_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_done) begin
                    n_prod = w_quo[COEF_W-1:0];
                    if (r_step == r_kf) begin
                        n_state = S_OUT;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.coefficient = r_prod;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_DIV))
        else $error("divider finished outside a divide step");

    a_mul_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_DIV))
        else $error("multiply step not followed by divide");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("transaction accepted but sequencer stayed idle");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_step >= N_W'(2)) && (r_step <= r_kf)))
        else $error("step index outside 2..folded k");

endmodule

`default_nettype wire
